// ----- src/sad_pkg.sv -----
// Package with the types, codes and tile step function of the sprite attribute decoder.
package sad_pkg;

   localparam int unsigned CsrIndexWidth = 1;
   localparam int unsigned CsrDataWidth  = 9;

   localparam logic [CsrIndexWidth-1:0] CSR_FLIP_SCREEN    = 1'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_DISPLAY_HEIGHT = 1'd1;

   localparam logic [8:0] DISPLAY_HEIGHT_RESET = 9'd224;

   localparam logic [7:0] SIZE_MASK   = 8'ha8;
   localparam logic [7:0] SIZE_ONE    = 8'h00;
   localparam logic [7:0] SIZE_TALL   = 8'h20;
   localparam logic [7:0] SIZE_WIDE   = 8'h08;
   localparam logic [7:0] SIZE_QUAD   = 8'h28;
   localparam logic [7:0] SIZE_DOUBLE = 8'ha0;

   localparam logic [9:0] X_BIAS     = 10'd71;
   localparam logic [9:0] Y_BIAS     = 10'd8;
   localparam logic [9:0] TILE_PIXELS = 10'd16;

   localparam logic [1:0] GFX_LOW  = 2'd0;
   localparam logic [1:0] GFX_MID  = 2'd1;
   localparam logic [1:0] GFX_HIGH = 2'd2;

   typedef enum logic [2:0] {
      MODE_ONE,
      MODE_TALL,
      MODE_WIDE,
      MODE_QUAD,
      MODE_DOUBLE
   } mode_type;

   typedef struct packed {
      logic [8:0]        code_base;
      logic [5:0]        color;
      logic              flip_x;
      logic              flip_y;
      logic signed [9:0] pos_x;
      logic signed [9:0] pos_y;
      mode_type          mode;
      logic [1:0]        last_idx;
   } slot_type;

   typedef struct packed {
      logic [1:0] code_add;
      logic       step_x;
      logic       step_y;
   } step_type;

   // Code offset and position steps of tile k within a sprite.
   function automatic step_type tile_step(mode_type mode, logic fx, logic fy, logic [1:0] k);
      step_type s;
      s = '0;
      unique case (mode)
         MODE_ONE: begin
            s = '0;
         end
         MODE_TALL: begin
            s.code_add = {k[0] ^ ~fy, 1'b0};
            s.step_y   = k[0];
         end
         MODE_WIDE: begin
            s.code_add = {1'b0, k[0]};
            s.step_x   = k[0] ^ fx;
         end
         MODE_QUAD: begin
            s.code_add = k ^ {~fy, fx};
            s.step_x   = k[0];
            s.step_y   = k[1];
         end
         MODE_DOUBLE: begin
            s.step_y = k[0];
         end
         default: begin
            s = '0;
         end
      endcase
      return s;
   endfunction

   function automatic logic [1:0] gfx_of(logic [8:0] code);
      logic [1:0] g;
      if (code[8]) begin
         g = GFX_HIGH;
      end else if (code[7]) begin
         g = GFX_MID;
      end else begin
         g = GFX_LOW;
      end
      return g;
   endfunction

endpackage

// ----- src/sad_slot_decode.sv -----
// Decoder from six sprite attribute bytes to a slot descriptor.
module sad_slot_decode
   import sad_pkg::*;
(
   input  logic [7:0] code_byte,
   input  logic [7:0] color_byte,
   input  logic [7:0] ypos_byte,
   input  logic [7:0] xpos_byte,
   input  logic [7:0] attr_a,
   input  logic [7:0] attr_b,
   input  logic       flip_screen,
   input  logic [8:0] display_height,
   output logic       emit,
   output slot_type   slot
);

   logic [8:0] code;
   logic       fx;
   logic       fy;
   logic       size_ok;
   mode_type   mode;
   logic [1:0] last_idx;

   always_comb begin
      code = {attr_a[6], code_byte};
      fx   = attr_a[0] ^ flip_screen;
      fy   = attr_a[1] ^ flip_screen;
      size_ok  = 1'b1;
      mode     = MODE_ONE;
      last_idx = 2'd0;
      unique case (attr_a & SIZE_MASK)
         SIZE_ONE: begin
            mode = MODE_ONE;
         end
         SIZE_TALL: begin
            mode     = MODE_TALL;
            last_idx = 2'd1;
            code[1]  = 1'b0;
         end
         SIZE_WIDE: begin
            mode     = MODE_WIDE;
            last_idx = 2'd1;
            code[0]  = 1'b0;
         end
         SIZE_QUAD: begin
            mode      = MODE_QUAD;
            last_idx  = 2'd3;
            code[1:0] = 2'b00;
         end
         SIZE_DOUBLE: begin
            mode     = MODE_DOUBLE;
            last_idx = 2'd1;
         end
         default: begin
            size_ok = 1'b0;
         end
      endcase
   end

   assign emit = size_ok && !attr_b[1];

   assign slot.code_base = code;
   assign slot.color     = color_byte[5:0];
   assign slot.flip_x    = fx;
   assign slot.flip_y    = fy;
   assign slot.pos_x     = {1'b0, attr_b[0], xpos_byte} - X_BIAS;
   assign slot.pos_y     = {1'b0, display_height} - {2'b00, ypos_byte} - Y_BIAS;
   assign slot.mode      = mode;
   assign slot.last_idx  = last_idx;

endmodule

// ----- src/sprite_attribute_decoder.sv -----
// Top level of the sprite attribute decoder: slot register, tile sequencer and result register.
//
// Each accepted slot beat is decoded into a slot register, and the tile sequencer then
// sends one tile command per cycle from it into the result register while the output is
// not stalled: a slot gives 1, 2 or 4 tiles, set by its size code, and a hidden slot
// or one with an unused size code gives none. The next slot is taken in the cycle that
// the last tile of the current one moves to the result register, so a stream of
// four-tile sprites runs with no gap between slots. Results are held in an output
// register and rsp_last marks the final tile of a slot.
module sprite_attribute_decoder
   import sad_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [7:0]               req_code_byte,
   input  logic [7:0]               req_color_byte,
   input  logic [7:0]               req_ypos_byte,
   input  logic [7:0]               req_xpos_byte,
   input  logic [7:0]               req_attr_a,
   input  logic [7:0]               req_attr_b,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [1:0]               rsp_gfx_set,
   output logic [8:0]               rsp_tile_code,
   output logic [5:0]               rsp_tile_color,
   output logic                     rsp_flip_x,
   output logic                     rsp_flip_y,
   output logic signed [9:0]        rsp_pos_x,
   output logic signed [9:0]        rsp_pos_y,
   output logic                     rsp_last
);

   logic       flip_screen_ff, flip_screen_in;
   logic [8:0] display_height_ff, display_height_in;

   logic       slot_valid_ff, slot_valid_in;
   slot_type   slot_ff, slot_in;
   logic [1:0] tile_idx_ff, tile_idx_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        gfx_ff, gfx_in;
   logic [8:0]        code_ff, code_in;
   logic [5:0]        color_ff;
   logic              fx_ff, fy_ff;
   logic signed [9:0] x_ff, x_in;
   logic signed [9:0] y_ff, y_in;
   logic              last_ff, last_in;

   logic     dec_emit;
   slot_type dec_slot;
   step_type step;
   logic     out_advance;
   logic     issue;
   logic     last_issue;
   logic     accept;

   sad_slot_decode u_decode (
      .code_byte      (req_code_byte),
      .color_byte     (req_color_byte),
      .ypos_byte      (req_ypos_byte),
      .xpos_byte      (req_xpos_byte),
      .attr_a         (req_attr_a),
      .attr_b         (req_attr_b),
      .flip_screen    (flip_screen_ff),
      .display_height (display_height_ff),
      .emit           (dec_emit),
      .slot           (dec_slot)
   );

   always_comb begin
      flip_screen_in    = flip_screen_ff;
      display_height_in = display_height_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FLIP_SCREEN: begin
               flip_screen_in = csr_wdata[0];
            end
            CSR_DISPLAY_HEIGHT: begin
               display_height_in = csr_wdata[8:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign out_advance = !rsp_valid_ff || rsp_ready;
   assign issue       = slot_valid_ff && out_advance;
   assign last_issue  = issue && (tile_idx_ff == slot_ff.last_idx);
   assign req_ready   = !slot_valid_ff || last_issue;
   assign accept      = req_valid && req_ready;

   always_comb begin
      slot_valid_in = slot_valid_ff;
      slot_in       = slot_ff;
      if (accept) begin
         slot_valid_in = dec_emit;
         slot_in       = dec_slot;
      end else if (last_issue) begin
         slot_valid_in = 1'b0;
      end
      if (last_issue || !slot_valid_ff) begin
         tile_idx_in = 2'd0;
      end else if (issue) begin
         tile_idx_in = tile_idx_ff + 2'd1;
      end else begin
         tile_idx_in = tile_idx_ff;
      end
   end

   always_comb begin
      step    = tile_step(slot_ff.mode, slot_ff.flip_x, slot_ff.flip_y, tile_idx_ff);
      code_in = slot_ff.code_base | {7'd0, step.code_add};
      gfx_in  = gfx_of(code_in);
      x_in    = slot_ff.pos_x + (step.step_x ? TILE_PIXELS : 10'd0);
      y_in    = slot_ff.pos_y - (step.step_y ? TILE_PIXELS : 10'd0);
      last_in = (tile_idx_ff == slot_ff.last_idx);
      rsp_valid_in = out_advance ? slot_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flip_screen_ff    <= 1'b0;
         display_height_ff <= DISPLAY_HEIGHT_RESET;
         slot_valid_ff     <= 1'b0;
         tile_idx_ff       <= 2'd0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         flip_screen_ff    <= flip_screen_in;
         display_height_ff <= display_height_in;
         slot_valid_ff     <= slot_valid_in;
         tile_idx_ff       <= tile_idx_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (issue) begin
         gfx_ff   <= gfx_in;
         code_ff  <= code_in;
         color_ff <= slot_ff.color;
         fx_ff    <= slot_ff.flip_x;
         fy_ff    <= slot_ff.flip_y;
         x_ff     <= x_in;
         y_ff     <= y_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_gfx_set    = gfx_ff;
   assign rsp_tile_code  = code_ff;
   assign rsp_tile_color = color_ff;
   assign rsp_flip_x     = fx_ff;
   assign rsp_flip_y     = fy_ff;
   assign rsp_pos_x      = x_ff;
   assign rsp_pos_y      = y_ff;
   assign rsp_last       = last_ff;

endmodule
